@@ sv/dss_pkg.sv @@
// shared types and codes for the drum step sequencer
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

	// request kinds carried on the input tuser
	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_TRACK = 3'd1;
	localparam logic [2:0] REQ_CELL  = 3'd2;
	localparam logic [2:0] REQ_START = 3'd3;
	localparam logic [2:0] REQ_STOP  = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd1;

	localparam logic [6:0]  STEPS_RESET  = 7'd16;
	localparam logic [15:0] PERIOD_RESET = 16'd5512;

	typedef struct packed {
		logic [2:0]        voice;
		logic              muted;
		logic              soloed;
		logic [7:0]        gain;
		logic signed [7:0] pan;
	} track_t;

	typedef struct packed {
		logic              active;
		logic [7:0]        velocity;
		logic signed [7:0] pitch;
	} cell_t;

	typedef struct packed {
		logic [2:0]        track;
		logic [2:0]        voice;
		logic [5:0]        step;
		logic [7:0]        amplitude;
		logic signed [7:0] pan;
		logic signed [7:0] pitch;
		logic              last;
	} trig_t;

endpackage

`default_nettype wire

@@ sv/dss_cell_mem.sv @@
// step cell memory with a clearing sweep after reset
`timescale 1ns / 1ps
`default_nettype none

module dss_cell_mem
	import dss_pkg::*;
#(
	parameter int AW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire cell_t         wdata,
	input  wire logic [AW-1:0] raddr,
	output cell_t              rdata,
	output logic               clr_busy
);

	cell_t           mem [2**AW];
	cell_t           rdata_q;
	logic            clr_busy_q;
	logic [AW-1:0]   clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata    = rdata_q;
	assign clr_busy = clr_busy_q;

endmodule

`default_nettype wire

@@ sv/dss_track_table.sv @@
// track settings table with solo summary
`timescale 1ns / 1ps
`default_nettype none

module dss_track_table
	import dss_pkg::*;
#(
	parameter int TRACKS = 8,
	parameter int TW     = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [TW-1:0] wr_idx,
	input  wire track_t        wr_entry,
	input  wire logic [TW-1:0] rd_idx,
	output track_t             rd_entry,
	output logic               any_solo
);

	track_t table_q [TRACKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACKS; i++) begin
				table_q[i] <= '0;
			end
		end else if (we) begin
			table_q[wr_idx] <= wr_entry;
		end
	end

	always_comb begin
		any_solo = 1'b0;
		for (int i = 0; i < TRACKS; i++) begin
			any_solo = any_solo | table_q[i].soloed;
		end
	end

	assign rd_entry = table_q[rd_idx];

endmodule

`default_nettype wire

@@ sv/dss_seq.sv @@
// request decode, step timing and the per-track trigger walk
`timescale 1ns / 1ps
`default_nettype none

module dss_seq
	import dss_pkg::*;
#(
	parameter int TRACKS    = 8,
	parameter int MAX_STEPS = 64,
	parameter int TW        = 3,
	parameter int SW        = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request side
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [2:0]       req,
	input  wire logic [2:0]       slot,
	input  wire logic [5:0]       cstep,
	// configuration
	input  wire logic [6:0]       steps_in_use,
	input  wire logic [15:0]      samples_per_step,
	// track table
	output logic                  tbl_we,
	output logic [TW-1:0]         tbl_wr_idx,
	output logic [TW-1:0]         tbl_rd_idx,
	input  wire track_t           tbl_rd,
	input  wire logic             any_solo,
	// cell memory
	input  wire logic             clr_busy,
	output logic                  mem_we,
	output logic [TW+SW-1:0]      mem_waddr,
	output logic [TW+SW-1:0]      mem_raddr,
	input  wire cell_t            mem_rdata,
	// trigger output
	output logic                  out_valid,
	input  wire logic             out_ready,
	output trig_t                 out_trig
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_EV   = 2'd2;
	localparam logic [1:0] ST_FL   = 2'd3;

	localparam logic [TW-1:0] LAST_TRACK = TW'(TRACKS - 1);

	logic [1:0]    state_q;
	logic          running_q;
	logic [SW-1:0] pos_q;
	logic [15:0]   cnt_q;
	logic [TW-1:0] walk_q;
	trig_t         pend_q;
	logic          pend_v_q;
	trig_t         out_q;
	logic          out_v_q;

	logic          accept;
	logic          slot_ok;
	logic          step_ok;
	logic          out_free;
	logic          out_load;
	logic          eligible;
	logic [15:0]   product;
	trig_t         cand;
	trig_t         pend_last;
	logic [SW:0]   pos_inc;
	logic [SW:0]   eff_len;
	logic [SW-1:0] pos_next;
	logic [15:0]   reload;

	assign in_ready = (state_q == ST_IDLE) && !clr_busy;
	assign accept   = in_valid && in_ready;
	assign slot_ok  = 32'(slot) < TRACKS;
	assign step_ok  = 32'(cstep) < MAX_STEPS;
	assign out_free = !out_v_q || out_ready;

	// pending trigger moves to the output on the next sounding track or at close
	assign out_load = out_free && pend_v_q &&
		(((state_q == ST_EV) && eligible) || (state_q == ST_FL));

	assign tbl_we     = accept && (req == REQ_TRACK) && slot_ok;
	assign tbl_wr_idx = TW'(slot);
	assign tbl_rd_idx = walk_q;
	assign mem_we     = accept && (req == REQ_CELL) && slot_ok && step_ok;
	assign mem_waddr  = {TW'(slot), SW'(cstep)};
	assign mem_raddr  = {walk_q, pos_q};

	// shared 8x8 multiplier, registered into the pending trigger
	assign product  = mem_rdata.velocity * tbl_rd.gain;
	assign eligible = !tbl_rd.muted && (!any_solo || tbl_rd.soloed) && mem_rdata.active;

	always_comb begin
		cand           = '0;
		cand.track     = 3'(walk_q);
		cand.voice     = tbl_rd.voice;
		cand.step      = 6'(pos_q);
		cand.amplitude = product[15:8];
		cand.pan       = tbl_rd.pan;
		cand.pitch     = mem_rdata.pitch;
		cand.last      = 1'b0;
	end

	always_comb begin
		pend_last      = pend_q;
		pend_last.last = 1'b1;
	end

	// step wrap against the clamped pattern length
	always_comb begin
		pos_inc = {1'b0, pos_q} + 1'b1;
		if (steps_in_use == 7'd0) begin
			eff_len = (SW+1)'(1);
		end else if (32'(steps_in_use) > MAX_STEPS) begin
			eff_len = (SW+1)'(MAX_STEPS);
		end else begin
			eff_len = (SW+1)'(steps_in_use);
		end
		pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[SW-1:0];
		reload   = (samples_per_step == 16'd0) ? 16'd0 : samples_per_step - 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= 1'b0;
			pos_q     <= '0;
			cnt_q     <= '0;
			walk_q    <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			out_v_q <= out_load || (out_v_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req)
							REQ_TICK: begin
								if (running_q) begin
									if (cnt_q != 16'd0) begin
										cnt_q <= cnt_q - 16'd1;
									end else begin
										walk_q  <= '0;
										state_q <= ST_RD;
									end
								end
							end
							REQ_START: begin
								if (!running_q) begin
									running_q <= 1'b1;
									pos_q     <= '0;
									cnt_q     <= '0;
								end
							end
							REQ_STOP: begin
								running_q <= 1'b0;
								pos_q     <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					if (!(eligible && pend_v_q && !out_free)) begin
						if (eligible) begin
							pend_v_q <= 1'b1;
						end
						if (walk_q == LAST_TRACK) begin
							state_q <= ST_FL;
						end else begin
							walk_q  <= walk_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_FL: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						pos_q    <= pos_next;
						cnt_q    <= reload;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= (state_q == ST_FL) ? pend_last : pend_q;
		end
		if (state_q == ST_EV && eligible && (!pend_v_q || out_free)) begin
			pend_q <= cand;
		end
	end

	assign out_valid = out_v_q;
	assign out_trig  = out_q;

endmodule

`default_nettype wire

@@ sv/drum_step_sequencer_top.sv @@
// top level of the drum step sequencer
//
// usage: requests enter on the s_axis channel, tuser carries the request kind
// (sample tick, track write, cell write, start, stop) and tdata the fields.
// triggers leave on the m_axis channel, one per sounding track of a step, in
// slot order, with tlast on the final trigger of the step.
// cfg_we / cfg_index / cfg_data set the pattern length and the step period;
// write them only while the block is idle.
// flow: writes, start, stop and non-firing ticks leave s_axis_tready high.
// a firing tick walks the tracks through one shared read-and-multiply path,
// a memory read state and an evaluate state per track, then a close state
// that ends the step, with s_axis_tready low throughout.
// a trigger leaves once the next sounding track is found; a step's final
// trigger leaves as the step closes.
// reset: the track table clears at once; the cell memory is swept to zero,
// one entry a cycle, over all 2**(track bits + step bits) entries (512 by default),
// while s_axis_tready stays low. the sequencer comes up stopped at step 0.
// stall: a trigger holds in the output register while m_axis_tready is low;
// one more trigger waits in a pending register and the walk pauses after.
`timescale 1ns / 1ps
`default_nettype none

module drum_step_sequencer_top
	import dss_pkg::*;
#(
	parameter int TRACKS    = 8,
	parameter int MAX_STEPS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request channel
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// track_slot, cell_step, cell_active, cell_velocity, cell_pitch,
	// set_voice, set_muted, set_soloed, set_gain, set_pan, zero pad
	input  wire logic [47:0]           s_axis_tdata,
	// req_type
	input  wire logic [2:0]            s_axis_tuser,
	// trigger channel
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// out_track, out_voice, out_step, out_amplitude, out_pan, out_pitch, zero pad
	output logic [39:0]                m_axis_tdata,
	output logic                       m_axis_tlast,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int SW = $clog2(MAX_STEPS);

	logic [6:0]  steps_q;
	logic [15:0] period_q;

	// request field unpack
	logic [2:0] slot;
	logic [5:0] cstep;
	cell_t      cell_in;
	track_t     track_in;

	assign slot              = s_axis_tdata[2:0];
	assign cstep             = s_axis_tdata[8:3];
	assign cell_in.active    = s_axis_tdata[9];
	assign cell_in.velocity  = s_axis_tdata[17:10];
	assign cell_in.pitch     = s_axis_tdata[25:18];
	assign track_in.voice    = s_axis_tdata[28:26];
	assign track_in.muted    = s_axis_tdata[29];
	assign track_in.soloed   = s_axis_tdata[30];
	assign track_in.gain     = s_axis_tdata[38:31];
	assign track_in.pan      = s_axis_tdata[46:39];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q  <= STEPS_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEPS:  steps_q  <= cfg_data[6:0];
				REG_PERIOD: period_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	logic          tbl_we;
	logic [TW-1:0] tbl_wr_idx;
	logic [TW-1:0] tbl_rd_idx;
	track_t        tbl_rd;
	logic          any_solo;

	logic             clr_busy;
	logic             mem_we;
	logic [TW+SW-1:0] mem_waddr;
	logic [TW+SW-1:0] mem_raddr;
	cell_t            mem_rdata;

	trig_t out_trig;

	dss_track_table #(
		.TRACKS (TRACKS),
		.TW     (TW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (tbl_we),
		.wr_idx   (tbl_wr_idx),
		.wr_entry (track_in),
		.rd_idx   (tbl_rd_idx),
		.rd_entry (tbl_rd),
		.any_solo (any_solo)
	);

	dss_cell_mem #(
		.AW (TW + SW)
	) u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (cell_in),
		.raddr    (mem_raddr),
		.rdata    (mem_rdata),
		.clr_busy (clr_busy)
	);

	dss_seq #(
		.TRACKS    (TRACKS),
		.MAX_STEPS (MAX_STEPS),
		.TW        (TW),
		.SW        (SW)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.req              (s_axis_tuser),
		.slot             (slot),
		.cstep            (cstep),
		.steps_in_use     (steps_q),
		.samples_per_step (period_q),
		.tbl_we           (tbl_we),
		.tbl_wr_idx       (tbl_wr_idx),
		.tbl_rd_idx       (tbl_rd_idx),
		.tbl_rd           (tbl_rd),
		.any_solo         (any_solo),
		.clr_busy         (clr_busy),
		.mem_we           (mem_we),
		.mem_waddr        (mem_waddr),
		.mem_raddr        (mem_raddr),
		.mem_rdata        (mem_rdata),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_trig         (out_trig)
	);

	// trigger pack, lowest field first
	assign m_axis_tdata = {4'b0000, out_trig.pitch, out_trig.pan, out_trig.amplitude,
		out_trig.step, out_trig.voice, out_trig.track};
	assign m_axis_tlast = out_trig.last;

endmodule

`default_nettype wire

@@ sv/dss_checker.sv @@
// port-level checks for the drum step sequencer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module dss_checker
	import dss_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [2:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// a stalled trigger holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("trigger changed while stalled");

	// while taking requests, only a step's final trigger can be waiting
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
		else $error("non-final trigger left while ready");

	// a request other than a tick never blocks the next one
	a_plain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_TICK) |=> s_axis_tready)
		else $error("ready dropped after a non-tick request");

	// requests other than ticks never produce triggers
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_TICK) &&
		(!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
		else $error("trigger after a non-tick request");

endmodule

bind drum_step_sequencer_top dss_checker u_dss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ verif/drum_step_sequencer_top_tb.sv @@
// self-checking testbench for the drum step sequencer top level
`timescale 1ns / 1ps

module drum_step_sequencer_top_tb;
	import dss_pkg::*;

	localparam int TRACK_COUNT    = 8;
	localparam int STEP_COUNT     = 64;
	// a firing tick holds s_axis_tready low while it walks all tracks; leave margin
	localparam int SETTLE_CYCLES  = 40;
	// cycles with no request or trigger moving before the run is abandoned
	localparam int WATCHDOG_LIMIT = 20000;

	// one queued request: kind on tuser, packed fields on tdata
	typedef struct {
		logic [2:0]  kind;
		logic [47:0] fields;
	} pend_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// track_slot, cell_step, cell_active, cell_velocity, cell_pitch,
	// set_voice, set_muted, set_soloed, set_gain, set_pan, zero pad
	logic [47:0]           s_axis_tdata = '0;
	// req_type
	logic [2:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// out_track, out_voice, out_step, out_amplitude, out_pan, out_pitch, zero pad
	logic [39:0]           m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// stimulus and expectations
	pend_req_t pending_reqs [$];
	trig_t     expected_trigs [$];
	int        error_count = 0;
	int        src_idle_pct = 0;
	int        snk_stall_pct = 0;
	int        idle_cycles = 0;

	// sequencer model state
	track_t      trk_model [TRACK_COUNT];
	cell_t       grid_model [TRACK_COUNT][STEP_COUNT];
	logic [5:0]  pos_model = '0;
	logic [15:0] countdown_model = '0;
	bit          running_model = 1'b0;
	logic [6:0]  steps_cfg = STEPS_RESET;
	logic [15:0] period_cfg = PERIOD_RESET;

	drum_step_sequencer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// request fields packed from bit 0 up, pad bit 47 left at zero
	function automatic logic [47:0] pack_request(
		input logic [2:0] slot, input logic [5:0] cstep, input logic active,
		input logic [7:0] vel, input logic [7:0] pitch, input logic [2:0] voice,
		input logic muted, input logic soloed, input logic [7:0] gain,
		input logic [7:0] pan);
		return {1'b0, pan, gain, soloed, muted, voice, pitch, vel, active, cstep, slot};
	endfunction

	// model update for one accepted request; queues the triggers it causes
	task automatic predict_request(input logic [2:0] kind, input logic [47:0] f);
		trig_t       trg_buf [TRACK_COUNT];
		int          n;
		int          len;
		bit          any_solo;
		logic [15:0] prod;
		n = 0;
		any_solo = 1'b0;
		case (kind)
			REQ_TICK: begin
				if (running_model) begin
					if (countdown_model != 0) begin
						countdown_model = countdown_model - 1'b1;
					end else begin
						for (int t = 0; t < TRACK_COUNT; t++)
							if (trk_model[t].soloed) any_solo = 1'b1;
						// slot order, muted never, solo masks the rest
						for (int t = 0; t < TRACK_COUNT; t++) begin
							if (trk_model[t].muted) continue;
							if (any_solo && !trk_model[t].soloed) continue;
							if (!grid_model[t][pos_model].active) continue;
							prod = grid_model[t][pos_model].velocity * trk_model[t].gain;
							trg_buf[n].track     = t[2:0];
							trg_buf[n].voice     = trk_model[t].voice;
							trg_buf[n].step      = pos_model;
							trg_buf[n].amplitude = prod[15:8];
							trg_buf[n].pan       = trk_model[t].pan;
							trg_buf[n].pitch     = grid_model[t][pos_model].pitch;
							trg_buf[n].last      = 1'b0;
							n++;
						end
						if (n > 0) trg_buf[n-1].last = 1'b1;
						for (int i = 0; i < n; i++)
							expected_trigs.insert(expected_trigs.size(), trg_buf[i]);
						// length of zero acts as one, above the grid as the grid
						len = steps_cfg;
						if (len == 0) len = 1;
						if (len > STEP_COUNT) len = STEP_COUNT;
						if (int'(pos_model) + 1 >= len) pos_model = '0;
						else pos_model = pos_model + 1'b1;
						// zero period acts as one
						countdown_model = (period_cfg == 0) ? 16'd0 : period_cfg - 1'b1;
					end
				end
			end
			REQ_TRACK: begin
				trk_model[f[2:0]] = '{voice: f[28:26], muted: f[29], soloed: f[30],
					gain: f[38:31], pan: f[46:39]};
			end
			REQ_CELL: begin
				grid_model[f[2:0]][f[8:3]] = '{active: f[9], velocity: f[17:10],
					pitch: f[25:18]};
			end
			REQ_START: begin
				if (!running_model) begin
					running_model = 1'b1;
					pos_model = '0;
					countdown_model = '0;
				end
			end
			REQ_STOP: begin
				running_model = 1'b0;
				pos_model = '0;
			end
			default: ;
		endcase
	endtask

	// request driver: hold until accepted, then maybe present the next one
	always @(posedge clk or negedge arst_n) begin : req_driver
		pend_req_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tuser, s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					nxt = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.fields;
					s_axis_tuser  <= nxt.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// trigger monitor: compare each accepted trigger with the oldest expected one
	always @(posedge clk or negedge arst_n) begin : trig_monitor
		trig_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_trigs.size() == 0) begin
					report_mismatch($sformatf("unexpected trigger track %0d step %0d",
						m_axis_tdata[2:0], m_axis_tdata[11:6]));
				end else begin
					want = expected_trigs.pop_front();
					if (m_axis_tdata[2:0] !== want.track)
						report_mismatch($sformatf("track got %0d want %0d",
							m_axis_tdata[2:0], want.track));
					if (m_axis_tdata[5:3] !== want.voice)
						report_mismatch($sformatf("voice got %0d want %0d (track %0d)",
							m_axis_tdata[5:3], want.voice, want.track));
					if (m_axis_tdata[11:6] !== want.step)
						report_mismatch($sformatf("step got %0d want %0d (track %0d)",
							m_axis_tdata[11:6], want.step, want.track));
					if (m_axis_tdata[19:12] !== want.amplitude)
						report_mismatch($sformatf("amplitude got %0d want %0d (track %0d)",
							m_axis_tdata[19:12], want.amplitude, want.track));
					if (m_axis_tdata[27:20] !== want.pan)
						report_mismatch($sformatf("pan got %0d want %0d (track %0d)",
							$signed(m_axis_tdata[27:20]), want.pan, want.track));
					if (m_axis_tdata[35:28] !== want.pitch)
						report_mismatch($sformatf("pitch got %0d want %0d (track %0d)",
							$signed(m_axis_tdata[35:28]), want.pitch, want.track));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("last got %0b want %0b (track %0d)",
							m_axis_tlast, want.last, want.track));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// watchdog: too long with nothing moving on either channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic add_plain(input logic [2:0] kind);
		pend_req_t r;
		// unused fields carry noise, the block has to ignore it
		r.kind = kind;
		r.fields = {1'b0, 15'($urandom), $urandom};
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic add_track(input logic [2:0] slot, input logic [2:0] voice,
		input logic muted, input logic soloed, input logic [7:0] gain,
		input logic [7:0] pan);
		pend_req_t r;
		r.kind = REQ_TRACK;
		r.fields = pack_request(slot, 6'($urandom), 1'($urandom), 8'($urandom),
			8'($urandom), voice, muted, soloed, gain, pan);
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic add_cell(input logic [2:0] slot, input logic [5:0] cstep,
		input logic active, input logic [7:0] vel, input logic [7:0] pitch);
		pend_req_t r;
		r.kind = REQ_CELL;
		r.fields = pack_request(slot, cstep, active, vel, pitch, 3'($urandom),
			1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// mostly ticks and cell writes inside the pattern, some control and noise
	task automatic add_random_requests(input int count, input int cell_hi);
		int pick;
		logic [5:0] cstep;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				add_plain(REQ_TICK);
			end else if (pick < 75) begin
				cstep = ($urandom_range(9) < 8) ? 6'($urandom_range(cell_hi)) : 6'($urandom);
				add_cell(3'($urandom), cstep, $urandom_range(3) != 0, 8'($urandom),
					8'($urandom));
			end else if (pick < 85) begin
				add_track(3'($urandom), 3'($urandom), $urandom_range(4) == 0,
					$urandom_range(7) == 0, 8'($urandom), 8'($urandom));
			end else if (pick < 90) begin
				add_plain(REQ_START);
			end else if (pick < 94) begin
				add_plain(REQ_STOP);
			end else if (pick < 97) begin
				add_plain(3'($urandom_range(7, 5)));
			end else begin
				add_plain(REQ_TICK);
			end
		end
	endtask

	// block idle: nothing queued, nothing in flight, walk finished
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_trigs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_STEPS) steps_cfg = val[6:0];
		else period_cfg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one phase: settle, reprogram, request a start, then random traffic
	task automatic run_phase(input int steps_val, input int period_val,
		input int src_pct, input int snk_pct, input int count);
		int hi;
		wait_idle();
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		write_reg(REG_STEPS, 16'(steps_val));
		write_reg(REG_PERIOD, 16'(period_val));
		hi = (steps_val == 0) ? 0 : (steps_val > STEP_COUNT ? STEP_COUNT - 1 : steps_val - 1);
		add_plain(REQ_START);
		add_random_requests(count, hi);
	endtask

	initial begin
		for (int t = 0; t < TRACK_COUNT; t++) begin
			trk_model[t] = '0;
			for (int s = 0; s < STEP_COUNT; s++) grid_model[t][s] = '0;
		end

		// single reset at the start, released away from the rising edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, reset length and period
		add_plain(REQ_TICK);                               // tick while stopped
		add_plain(3'd5);                                   // unknown kinds ignored
		add_plain(3'd7);
		add_track(3'd0, 3'd7, 1'b0, 1'b0, 8'hFF, 8'h7F);   // full gain, hard right
		add_track(3'd1, 3'd0, 1'b0, 1'b0, 8'h80, 8'h80);   // hard left
		add_track(3'd2, 3'd3, 1'b1, 1'b0, 8'hFF, 8'h00);   // muted track
		add_track(3'd7, 3'd5, 1'b0, 1'b0, 8'h00, 8'hFF);   // zero gain
		add_cell(3'd0, 6'd0, 1'b1, 8'hFF, 8'h7F);
		add_cell(3'd1, 6'd0, 1'b1, 8'hFF, 8'h80);
		add_cell(3'd2, 6'd0, 1'b1, 8'h0A, 8'h05);          // silenced by mute
		add_cell(3'd7, 6'd0, 1'b1, 8'hC8, 8'hFF);
		add_cell(3'd0, 6'd63, 1'b1, 8'h01, 8'h00);         // last grid column
		add_cell(3'd3, 6'd0, 1'b0, 8'hFF, 8'h00);          // inactive cell
		add_cell(3'd7, 6'd1, 1'b1, 8'h00, 8'h00);          // zero velocity
		add_plain(REQ_START);
		add_plain(REQ_TICK);                               // first tick fires step 0
		add_plain(REQ_START);                              // start while running ignored
		add_plain(REQ_TICK);                               // countdown only
		add_plain(REQ_STOP);
		add_track(3'd1, 3'd0, 1'b0, 1'b1, 8'h80, 8'h80);   // solo masks other tracks
		add_plain(REQ_START);
		add_plain(REQ_TICK);
		add_plain(REQ_STOP);
		add_track(3'd1, 3'd0, 1'b0, 1'b0, 8'h80, 8'h80);

		// random phases across lengths, periods and flow-control mixes
		run_phase(4, 1, 0, 0, 80);
		run_phase(0, 0, 74, 0, 70);        // zero length and zero period
		run_phase(64, 2, 0, 74, 70);
		run_phase(127, 3, 37, 37, 70);     // length above the grid
		run_phase(37, 65535, 0, 0, 25);    // longest period
		run_phase(16, 1, 37, 37, 70);

		wait_idle();
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ drum_step_sequencer_top.f @@
sv/dss_pkg.sv
sv/dss_cell_mem.sv
sv/dss_track_table.sv
sv/dss_seq.sv
sv/drum_step_sequencer_top.sv
sv/dss_checker.sv
verif/drum_step_sequencer_top_tb.sv
